// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER_AT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER_AT(label, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/ise_pkg.sv -----
// ----------------------------------------------------------------------------
// ise_pkg
// types, constants and bit search helpers of the integer set successor engine
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned SIDE      = 16;
  localparam int unsigned NCLUSTERS = 16;
  localparam int unsigned CLU_W     = 4;
  localparam int unsigned LOW_W     = 4;

  typedef logic [SIDE-1:0]      word_t;
  typedef logic [NCLUSTERS-1:0] summary_t;
  typedef logic [CLU_W-1:0]     clu_t;
  typedef logic [LOW_W-1:0]     low_t;
  typedef logic [KEY_W-1:0]     key_t;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_MEMBER = 3'd2,
    OP_MIN    = 3'd3,
    OP_MAX    = 3'd4,
    OP_SUCC   = 3'd5,
    OP_PRED   = 3'd6
  } operation_e;

  // index of lowest set bit, zero when none
  function automatic low_t first_idx(input word_t v);
    low_t idx;
    idx = '0;
    for (int i = SIDE - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = LOW_W'(i);
      end
    end
    return idx;
  endfunction

  // index of highest set bit, zero when none
  function automatic low_t last_idx(input word_t v);
    low_t idx;
    idx = '0;
    for (int i = 0; i < SIDE; i++) begin
      if (v[i]) begin
        idx = LOW_W'(i);
      end
    end
    return idx;
  endfunction

  // bits strictly above position l
  function automatic word_t gt_mask(input low_t l);
    word_t m;
    for (int i = 0; i < SIDE; i++) begin
      m[i] = (i > int'(l));
    end
    return m;
  endfunction

  // bits strictly below position l
  function automatic word_t lt_mask(input low_t l);
    word_t m;
    for (int i = 0; i < SIDE; i++) begin
      m[i] = (i < int'(l));
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/ise_ram.sv -----
// ----------------------------------------------------------------------------
// ise_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ise_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/integer_set_successor_engine.sv -----
// ----------------------------------------------------------------------------
// integer_set_successor_engine
// result strobe follows a taken start through ST_EVAL and the result
// register; successor and predecessor that must move on to another cluster
// word also pass through ST_EVAL2. the cluster ram read is registered. the next
// word is taken in the cycle its result is shown, no sooner; receiver can't stall
// reset empties the set at once by clearing the summary, no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_set_successor_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        operation_i,
  input  ise_pkg::key_t     key_i,
  output logic              result_valid_o,
  output logic              found_o,
  output ise_pkg::key_t     answer_key_o
);
  import ise_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EVAL2
  } state_e;

  state_e     state_q, state_d;
  summary_t   summary_q, summary_d;
  operation_e op_q, op_d;
  key_t       key_q, key_d;
  clu_t       clu_q, clu_d;
  logic       live_q, live_d;
  logic       valid_q, valid_d;
  logic       found_q, found_d;
  key_t       ans_q, ans_d;

  logic       accept;
  operation_e op_in;
  logic       ram_we, ram_re;
  clu_t       ram_raddr;
  word_t      ram_wdata, ram_rdata;
  word_t      word, bit_sel, own_gt, own_lt;
  summary_t   sum_gt, sum_lt;
  clu_t       h;
  low_t       lo;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign op_in  = operation_e'(operation_i);

  assign h       = key_q[KEY_W-1:LOW_W];
  assign lo      = key_q[LOW_W-1:0];
  // cluster never written or emptied reads as zero
  assign word    = live_q ? ram_rdata : '0;
  assign bit_sel = word_t'(1) << lo;
  assign own_gt  = word & gt_mask(lo);
  assign own_lt  = word & lt_mask(lo);
  assign sum_gt  = summary_q & gt_mask(h);
  assign sum_lt  = summary_q & lt_mask(h);

  always_comb begin
    state_d   = state_q;
    summary_d = summary_q;
    op_d      = op_q;
    key_d     = key_q;
    clu_d     = clu_q;
    valid_d   = 1'b0;
    found_d   = found_q;
    ans_d     = ans_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = clu_q;
    ram_wdata = word;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d   = op_in;
          key_d  = key_i;
          ram_re = 1'b1;
          if (op_in == OP_MIN) begin
            ram_raddr = first_idx(summary_q);
          end else if (op_in == OP_MAX) begin
            ram_raddr = last_idx(summary_q);
          end else begin
            ram_raddr = key_i[KEY_W-1:LOW_W];
          end
          clu_d   = ram_raddr;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        valid_d = 1'b1;
        found_d = 1'b0;
        ans_d   = '0;
        unique case (op_q)
          OP_INSERT: begin
            ram_we       = 1'b1;
            ram_wdata    = word | bit_sel;
            summary_d[h] = 1'b1;
            found_d      = 1'b1;
          end
          OP_DELETE: begin
            ram_we    = 1'b1;
            ram_wdata = word & ~bit_sel;
            if ((word & ~bit_sel) == '0) begin
              summary_d[h] = 1'b0;
            end
            found_d = 1'b1;
          end
          OP_MEMBER: begin
            found_d = word[lo];
          end
          OP_MIN: begin
            found_d = |word;
            if (|word) begin
              ans_d = {clu_q, first_idx(word)};
            end
          end
          OP_MAX: begin
            found_d = |word;
            if (|word) begin
              ans_d = {clu_q, last_idx(word)};
            end
          end
          OP_SUCC: begin
            if (|own_gt) begin
              found_d = 1'b1;
              ans_d   = {h, first_idx(own_gt)};
            end else if (|sum_gt) begin
              ram_re    = 1'b1;
              ram_raddr = first_idx(sum_gt);
              clu_d     = ram_raddr;
              valid_d   = 1'b0;
              state_d   = ST_EVAL2;
            end
          end
          OP_PRED: begin
            if (|own_lt) begin
              found_d = 1'b1;
              ans_d   = {h, last_idx(own_lt)};
            end else if (|sum_lt) begin
              ram_re    = 1'b1;
              ram_raddr = last_idx(sum_lt);
              clu_d     = ram_raddr;
              valid_d   = 1'b0;
              state_d   = ST_EVAL2;
            end
          end
          default: begin
            found_d = 1'b0;
          end
        endcase
      end
      ST_EVAL2: begin
        state_d = ST_IDLE;
        valid_d = 1'b1;
        found_d = |word;
        if (op_q == OP_SUCC) begin
          ans_d = {clu_q, first_idx(word)};
        end else begin
          ans_d = {clu_q, last_idx(word)};
        end
        if (!(|word)) begin
          ans_d = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign live_d = ram_re ? summary_q[ram_raddr] : live_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      summary_q <= '0;
      valid_q   <= 1'b0;
      live_q    <= 1'b0;
      op_q      <= OP_INSERT;
      key_q     <= '0;
      clu_q     <= '0;
      found_q   <= 1'b0;
      ans_q     <= '0;
    end else begin
      state_q   <= state_d;
      summary_q <= summary_d;
      valid_q   <= valid_d;
      live_q    <= live_d;
      op_q      <= op_d;
      key_q     <= key_d;
      clu_q     <= clu_d;
      found_q   <= found_d;
      ans_q     <= ans_d;
    end
  end

  ise_ram #(
    .WIDTH(SIDE),
    .DEPTH(NCLUSTERS)
  ) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (h),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o = valid_q;
  assign found_o        = found_q;
  assign answer_key_o   = ans_q;

  `ASSERT_AT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `ASSERT_AT(a_result_idle, clk_i, rst_ni, result_valid_o |-> !busy)
  `ASSERT_AT(a_result_after_work, clk_i, rst_ni, result_valid_o |-> $past(busy))
  `ASSERT_NEVER_AT(a_key_without_find, clk_i, rst_ni, result_valid_o && !found_o && (|answer_key_o))
  `ASSERT_NEVER_AT(a_ram_port_clash, clk_i, rst_ni, ram_we && ram_re)

endmodule

// ----- dv/tb_integer_set_successor_engine.sv -----
// ----------------------------------------------------------------------------
// tb_integer_set_successor_engine
// self-checking bench for the integer set successor engine
//
// a clocked driver offers words from a pending queue with random gaps, and a
// clocked monitor predicts each taken word against a shadow copy of the key
// set and checks every result strobe in order. a directed opening covers the
// empty set, both ends of the key range, cluster crossings and the spare
// opcode; random phases then vary density and key spread, with a full drain
// between phases and no gaps in the last one
// ----------------------------------------------------------------------------
module tb_integer_set_successor_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ise_pkg::*;

  localparam logic [2:0] OP_SPARE  = 3'd7;
  localparam int         LIMIT     = 200000;
  localparam int         PHASES    = 6;
  localparam int         PHASE_LEN = 300;

  typedef struct packed {
    logic [2:0] operation;
    key_t       key;
  } cmd_word_t;

  typedef struct packed {
    logic found;
    key_t answer_key;
  } lookup_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] operation_i = '0;
  key_t       key_i = '0;
  logic       result_valid_o;
  logic       found_o;
  key_t       answer_key_o;

  cmd_word_t  pending_words[$];
  lookup_t    due_results[$];
  logic [255:0] key_set = '0;

  int  words_queued = 0;
  int  words_taken = 0;
  int  gap_left = 0;
  int  cycles = 0;
  int  err_count = 0;
  bit  word_taken = 1'b0;
  bit  no_gaps = 1'b0;
  int  gap_odds = 3;

  integer_set_successor_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .key_i          (key_i),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .answer_key_o   (answer_key_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow set: apply one word and work out its result
  task automatic apply_word(input cmd_word_t w, output lookup_t res);
    int i;
    res = '0;
    case (w.operation)
      OP_INSERT: begin
        key_set[w.key] = 1'b1;
        res.found = 1'b1;
      end
      OP_DELETE: begin
        key_set[w.key] = 1'b0;
        res.found = 1'b1;
      end
      OP_MEMBER: res.found = key_set[w.key];
      OP_MIN: begin
        for (i = 255; i >= 0; i--) begin
          if (key_set[i]) begin
            res.found = 1'b1;
            res.answer_key = key_t'(i);
          end
        end
      end
      OP_MAX: begin
        for (i = 0; i < 256; i++) begin
          if (key_set[i]) begin
            res.found = 1'b1;
            res.answer_key = key_t'(i);
          end
        end
      end
      OP_SUCC: begin
        for (i = 255; i > int'(w.key); i--) begin
          if (key_set[i]) begin
            res.found = 1'b1;
            res.answer_key = key_t'(i);
          end
        end
      end
      OP_PRED: begin
        for (i = 0; i < int'(w.key); i++) begin
          if (key_set[i]) begin
            res.found = 1'b1;
            res.answer_key = key_t'(i);
          end
        end
      end
      default: res = '0;
    endcase
  endtask

  task automatic queue_word(input logic [2:0] op, input key_t k);
    cmd_word_t w;
    w.operation = op;
    w.key = k;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // random word shaped by phase: spread, density and key range differ
  task automatic queue_random(input int mode);
    int   r;
    logic [2:0] op;
    key_t k;
    r = $urandom_range(0, 99);
    case (mode)
      1: op = (r < 45) ? OP_INSERT : (r < 50) ? OP_DELETE : 3'($urandom_range(2, 7));
      2: op = (r < 10) ? OP_INSERT : (r < 50) ? OP_DELETE : 3'($urandom_range(2, 7));
      default: op = (r < 25) ? OP_INSERT : (r < 40) ? OP_DELETE : 3'($urandom_range(2, 7));
    endcase
    if (r % 17 == 0) begin
      op = OP_SPARE;
    end
    k = key_t'($urandom);
    case (mode)
      3: k = {($urandom_range(0, 1) != 0) ? 4'h2 : 4'hd, 4'($urandom)};
      4: k = {4'($urandom), ($urandom_range(0, 1) != 0) ? 4'h0 : 4'hf};
      default: ;
    endcase
    queue_word(op, k);
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || due_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!start || word_taken)) begin
      word_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() != 0) begin
        start <= 1'b1;
        operation_i <= pending_words[0].operation;
        key_i <= pending_words[0].key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results checked first, then the word taken at this edge
  always @(posedge clk_i) begin
    lookup_t   want;
    cmd_word_t w;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (due_results.size() == 0) begin
          $error("result with none due: found %0b answer_key %0d", found_o, answer_key_o);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0b actual %0b", want.found, found_o);
            err_count++;
          end
          if (answer_key_o !== want.answer_key) begin
            $error("answer_key: expected %0d actual %0d", want.answer_key, answer_key_o);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        w = pending_words.pop_front();
        apply_word(w, want);
        due_results.push_back(want);
        words_taken++;
        word_taken = 1'b1;
        if (!no_gaps && $urandom_range(0, gap_odds) == 0) begin
          gap_left = $urandom_range(1, 4);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty set, spare opcode, range ends, cluster crossings
    queue_word(OP_MIN, 8'h00);
    queue_word(OP_MAX, 8'hff);
    queue_word(OP_SUCC, 8'h00);
    queue_word(OP_PRED, 8'hff);
    queue_word(OP_MEMBER, 8'h00);
    queue_word(OP_DELETE, 8'h80);
    queue_word(OP_SPARE, 8'h55);
    queue_word(OP_INSERT, 8'h00);
    queue_word(OP_INSERT, 8'hff);
    queue_word(OP_INSERT, 8'h0f);
    queue_word(OP_INSERT, 8'h10);
    queue_word(OP_INSERT, 8'h10);
    queue_word(OP_MEMBER, 8'hff);
    queue_word(OP_MIN, 8'haa);
    queue_word(OP_MAX, 8'h55);
    queue_word(OP_SUCC, 8'h0f);
    queue_word(OP_SUCC, 8'h10);
    queue_word(OP_PRED, 8'h10);
    queue_word(OP_PRED, 8'h00);
    queue_word(OP_SUCC, 8'hff);
    queue_word(OP_DELETE, 8'h10);
    queue_word(OP_PRED, 8'hff);
    queue_word(OP_DELETE, 8'hff);
    queue_word(OP_DELETE, 8'h0f);
    queue_word(OP_SPARE, 8'hff);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      gap_odds = (p % 2 == 0) ? 3 : 1;
      no_gaps = (p == PHASES - 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        queue_random(p % 5);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ise_pkg.sv
rtl/core/ise_ram.sv
rtl/core/integer_set_successor_engine.sv
dv/tb_integer_set_successor_engine.sv
